### sv/tkf_pkg.sv
// shared types and constants for the tilt kalman filter
`default_nettype none
package tkf_pkg;
   localparam int CfgWidth = 15;
   localparam int DataWidth = 16;
   localparam int CsrIdxWidth = 2;
   localparam logic [CsrIdxWidth-1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RATE_GAIN = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MEAS_VAR = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PROC_VAR = 2'd3;
   localparam logic signed [DataWidth-1:0] CovReset = 16'sd204;

   // truncating shift right by 8 of a 32-bit value (toward zero)
   function automatic logic signed [31:0] div256(input logic signed [31:0] v);
      logic signed [31:0] b;
      b = v + (v[31] ? 32'sd255 : 32'sd0);
      return b >>> 8;
   endfunction
endpackage
`default_nettype wire

### sv/tkf_div.sv
// iterative signed 32/16 divider, one quotient bit per cycle
`default_nettype none
module tkf_div import tkf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] dividend,
   input  wire logic signed [15:0] divisor,
   output logic                    done,
   output logic signed [31:0]      quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [15:0] den_ff, den_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] trial;
   logic [31:0] rem_sh;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      rem_sh = {rem_ff[30:0], quo_ff[31]};
      trial = {1'b0, rem_sh} - {17'd0, den_ff};
      if (start) begin
         quo_in = dividend[31] ? 32'(-dividend) : dividend;
         den_in = divisor[15] ? 16'(-divisor) : divisor;
         neg_in = dividend[31] ^ divisor[15];
         rem_in = '0; cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0]; quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh; quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      neg_ff <= neg_in; cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? 32'(-quo_ff) : quo_ff;
endmodule
`default_nettype wire

### sv/tilt_kalman_filter_q8_8.sv
// top level of the two-state q8.8 tilt kalman filter
// each sample runs fourteen products on one shared multiplier and two gain divides on one
// bit-serial divider; the divides are skipped when the innovation covariance is zero, and a new
// request is accepted only after the response has been taken
// reset: synchronous, active high; registers and filter state return to defaults
`default_nettype none
module tilt_kalman_filter_q8_8 import tkf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [31:0]            req_tdata,   // gyro_rate[15:0], tilt_meas[31:16]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [31:0]                 rsp_tdata,   // angle_est[15:0], bias_est[31:16]
   output logic                        rsp_tuser,   // div_zero
   input  wire logic                   csr_we,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CfgWidth-1:0]    csr_wdata
);
   typedef enum logic [2:0] {IDLE, MUL, DIV0, DIV1, OUT} state_type;
   // micro-steps of the multiply sequence, in issue order
   typedef enum logic [3:0] {
      S_TS_BIAS, S_RG_RATE, S_TS_P10, S_TS_P11, S_K0_INN, S_K1_INN, S_K0_P01,
      S_K1_P01, S_P11_TS, S_K1_P00, S_M2_TS, S_AP01_TS, S_K0_P00, S_M1_TS
   } step_type;
   typedef logic signed [DataWidth-1:0] s16_type;
   typedef logic signed [23:0] s24_type;
   typedef logic signed [31:0] s32_type;

   // configuration
   logic [CfgWidth-1:0] ts_ff, rg_ff, mv_ff, pv_ff;
   // filter state
   s16_type angle_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   // step temporaries
   s16_type rate_ff, tilt_ff, pred_ff, inn_ff, s_ff, ap00_ff, ap01_ff, k0_ff, k1_ff;
   s24_type m1_ff, m2_ff;      // k0*p01/256, k1*p01/256, kept unwrapped
   s32_type acc_ff;            // product accumulator
   s32_type prod_ff;           // registered multiplier output
   logic    dz_ff;
   logic    half_ff;           // low: issue product, high: consume it
   logic    dgo_ff;            // divider start pulse
   state_type state_ff;
   step_type  step_ff;
   s16_type s_in;
   s16_type ts_op, rg_op;
   s24_type ma;
   s16_type mb;
   s32_type prod;
   s32_type div_num;
   logic    go_div;
   logic    ddone;
   s32_type dquo;

   // gain dividends are ap00*256 and p10*256, sign extended
   assign div_num = (state_ff == DIV1) ? {{8{p10_ff[15]}}, p10_ff, 8'd0}
                                       : {{8{ap00_ff[15]}}, ap00_ff, 8'd0};

   tkf_div u_div (
      .clock(clock), .reset(reset), .start(dgo_ff),
      .dividend(div_num), .divisor(s_ff), .done(ddone), .quotient(dquo)
   );

   assign s_in = p00_ff + s16_type'({1'b0, mv_ff});
   assign ts_op = s16_type'({1'b0, ts_ff});
   assign rg_op = s16_type'({1'b0, rg_ff});

   // shared multiplier operand select; product registered next cycle
   always_comb begin
      ma = '0; mb = '0;
      case (step_ff)
         S_TS_BIAS: begin ma = s24_type'(bias_ff); mb = ts_op; end
         S_RG_RATE: begin ma = s24_type'(rate_ff); mb = rg_op; end
         S_TS_P10:  begin ma = s24_type'(p10_ff);  mb = ts_op; end
         S_TS_P11:  begin ma = s24_type'(p11_ff);  mb = ts_op; end
         S_K0_INN:  begin ma = s24_type'(inn_ff);  mb = k0_ff; end
         S_K1_INN:  begin ma = s24_type'(inn_ff);  mb = k1_ff; end
         S_K0_P01:  begin ma = s24_type'(p01_ff);  mb = k0_ff; end
         S_K1_P01:  begin ma = s24_type'(p01_ff);  mb = k1_ff; end
         S_P11_TS:  begin ma = s24_type'(p11_ff);  mb = ts_op; end
         S_K1_P00:  begin ma = s24_type'(p00_ff);  mb = k1_ff; end
         S_M2_TS:   begin ma = m2_ff;              mb = ts_op; end
         S_AP01_TS: begin ma = s24_type'(ap01_ff); mb = ts_op; end
         S_K0_P00:  begin ma = s24_type'(p00_ff);  mb = k0_ff; end
         S_M1_TS:   begin ma = m1_ff;              mb = ts_op; end
         default:   begin ma = '0; mb = '0; end
      endcase
   end
   // products wrap to 32 bits
   assign prod = s32_type'(ma) * s32_type'(mb);

   // start the first divide after the last predict product, the second after the first
   assign go_div = (state_ff == MUL && half_ff && step_ff == S_TS_P11 && !dz_ff)
                   || (state_ff == DIV0 && ddone);

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff <= 15'd25; rg_ff <= 15'd25; mv_ff <= 15'd25; pv_ff <= '0;
         angle_ff <= '0; bias_ff <= '0; p00_ff <= CovReset; p01_ff <= '0;
         p10_ff <= '0; p11_ff <= CovReset;
         state_ff <= IDLE; step_ff <= S_TS_BIAS; half_ff <= 1'b0; dgo_ff <= 1'b0;
         dz_ff <= 1'b0;
      end else begin
         dgo_ff <= go_div;
         if (csr_we) begin
            case (csr_index)
               CSR_TIME_STEP: ts_ff <= csr_wdata;
               CSR_RATE_GAIN: rg_ff <= csr_wdata;
               CSR_MEAS_VAR:  mv_ff <= csr_wdata;
               CSR_PROC_VAR:  pv_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            IDLE: if (req_tvalid) begin
               rate_ff <= req_tdata[15:0]; tilt_ff <= req_tdata[31:16];
               s_ff <= s_in;
               dz_ff <= (s_in == '0);
               k0_ff <= '0; k1_ff <= '0;
               step_ff <= S_TS_BIAS; half_ff <= 1'b0; state_ff <= MUL;
            end
            MUL: begin
               if (!half_ff) begin
                  prod_ff <= prod;
                  half_ff <= 1'b1;
               end else begin
                  half_ff <= 1'b0;
                  // consume the registered product; covariance uses pre-step values
                  case (step_ff)
                     S_TS_BIAS: acc_ff <= prod_ff;
                     S_RG_RATE: pred_ff <= angle_ff + s16_type'(div256(acc_ff + prod_ff));
                     S_TS_P10: begin
                        ap00_ff <= p00_ff + s16_type'(div256(prod_ff));
                        inn_ff <= tilt_ff - pred_ff;
                     end
                     S_TS_P11:  ap01_ff <= p01_ff + s16_type'(div256(prod_ff));
                     S_K0_INN:  angle_ff <= pred_ff + s16_type'(div256(prod_ff));
                     S_K1_INN:  bias_ff <= bias_ff + s16_type'(div256(prod_ff));
                     S_K0_P01:  m1_ff <= s24_type'(div256(prod_ff));
                     S_K1_P01:  m2_ff <= s24_type'(div256(prod_ff));
                     S_P11_TS:  acc_ff <= prod_ff;
                     S_K1_P00:  acc_ff <= div256(acc_ff - prod_ff);
                     S_M2_TS: begin
                        p10_ff <= p10_ff + s16_type'(acc_ff) - s16_type'(div256(prod_ff));
                        p11_ff <= p11_ff - s16_type'(m2_ff);
                     end
                     S_AP01_TS: acc_ff <= prod_ff;
                     S_K0_P00:  acc_ff <= div256(acc_ff - prod_ff);
                     S_M1_TS: begin
                        p00_ff <= ap00_ff + s16_type'(acc_ff) - s16_type'(div256(prod_ff))
                                  + s16_type'({1'b0, pv_ff});
                        p01_ff <= ap01_ff - s16_type'(m1_ff);
                     end
                     default: ;
                  endcase
                  // sequence: predict products, gain divides unless dz is set, update products
                  case (step_ff)
                     S_TS_P11: begin
                        if (dz_ff) step_ff <= S_K0_INN;   // zero gains, skip divides
                        else state_ff <= DIV0;
                     end
                     S_M1_TS: state_ff <= OUT;
                     default: step_ff <= step_type'(step_ff + 4'd1);
                  endcase
               end
            end
            DIV0: if (ddone) begin
               k0_ff <= s16_type'(dquo); state_ff <= DIV1;
            end
            DIV1: if (ddone) begin
               k1_ff <= s16_type'(dquo); step_ff <= S_K0_INN; state_ff <= MUL;
            end
            OUT: if (rsp_tready) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = (state_ff == OUT);
   assign rsp_tdata = {bias_ff, angle_ff};
   assign rsp_tuser = dz_ff;
endmodule
`default_nettype wire
